>>> rtl/ofs_cal_pkg.sv
// package for the current offset calibration block: beat types, constants and state codes
package ofs_cal_pkg;

    localparam int SUM_W    = 32;
    localparam int OFS_W    = 16;
    localparam int TICK_W   = 14;
    localparam int TIMER_W  = 8;
    localparam int CNT_W    = 5;
    localparam int DIV_W    = 14;
    localparam int BUS_W    = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FREQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY   = 1'b1;

    localparam logic [7:0]  PWM_FREQ_RESET = 8'd50;
    localparam logic [9:0]  SUPPLY_RESET   = 10'd380;

    localparam logic [11:0]        VCLASS_THRESHOLD = 12'd1366;
    localparam logic [BUS_W-1:0]   BUS_LO_MUL       = 20'd181;
    localparam logic [BUS_W-1:0]   BUS_HI_MUL       = 20'd543;
    localparam logic [TIMER_W-1:0] TIMER_LIMIT      = 8'd10;
    localparam logic [TIMER_W-1:0] TIMER_MAX        = 8'd255;
    localparam logic [CNT_W-1:0]   LAST_BIT         = 5'd31;

    typedef struct packed {
        logic signed [15:0] phase_a_current;
        logic signed [15:0] phase_b_current;
        logic [10:0]        dc_bus_volts;
        logic [11:0]        vclass_adc;
    } sample_beat_t;

    typedef struct packed {
        logic signed [15:0] offset_a;
        logic signed [15:0] offset_b;
        logic               cal_done;
        logic               class_high;
        logic               charge_fault;
    } result_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } cal_state_t;

endpackage

>>> rtl/current_offset_calibration.sv
// current sensor offset calibration: settle, bit-serial averaging and bit-serial division
//
// One sample beat per PWM tick, one result beat per sample. With F the PWM frequency code,
// the first 2*F+1 samples only let the ADC settle, the next 38*F are summed (phase A and
// phase B), and the sample after that divides both sums by 38*F, truncating toward zero,
// and raises cal_done; from then on every beat repeats the held result. During the
// summing window class_high follows the last vclass reading against 1366, and a
// saturating up/down timer watches the DC bus against 0.5 and 1.5 times supply*181/128;
// charge_fault is sticky once the timer passes 10. Sums are kept in 32-bit shift registers
// and added one bit per clock; the final sample runs a restoring divider one quotient bit
// per clock on the same shift registers; settle and held samples skip both and go straight
// to the output. A result held back by the sink stalls the block only when the next result
// is ready to be written. The result register lets the next sample be taken while a result
// still waits. Configuration writes should only be made while the block is idle.
module current_offset_calibration (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ofs_cal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ofs_cal_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  ofs_cal_pkg::sample_beat_t           sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ofs_cal_pkg::result_beat_t           result
);
    import ofs_cal_pkg::*;

    logic [7:0]         pwm_freq_reg;
    logic [9:0]         supply_reg;

    cal_state_t         state_reg, state_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [SUM_W-1:0]   sum_a_reg, sum_a_next;
    logic [SUM_W-1:0]   sum_b_reg, sum_b_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               fault_reg, fault_next;
    logic               class_reg, class_next;
    logic               done_reg, done_next;
    logic [OFS_W-1:0]   ofs_a_reg, ofs_a_next;
    logic [OFS_W-1:0]   ofs_b_reg, ofs_b_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               carry_a_reg, carry_a_next;
    logic               carry_b_reg, carry_b_next;
    logic               result_valid_reg, result_valid_next;

    logic [OFS_W-1:0]   a_sh_reg, a_sh_next;
    logic [OFS_W-1:0]   b_sh_reg, b_sh_next;
    logic [DIV_W-1:0]   rem_a_reg, rem_a_next;
    logic [DIV_W-1:0]   rem_b_reg, rem_b_next;
    logic [OFS_W-1:0]   q_a_reg, q_a_next;
    logic [OFS_W-1:0]   q_b_reg, q_b_next;
    logic               neg_a_reg, neg_a_next;
    logic               neg_b_reg, neg_b_next;
    result_beat_t       result_reg, result_next;

    logic [TICK_W-1:0]  start_tick;
    logic [TICK_W-1:0]  end_tick;
    logic [DIV_W-1:0]   divisor;
    logic [BUS_W-1:0]   bus_scaled;
    logic [BUS_W-1:0]   bus_lo;
    logic [BUS_W-1:0]   bus_hi;
    logic               bus_outside;
    logic [TIMER_W-1:0] timer_upd;
    logic               bit_a;
    logic               bit_b;
    logic               sbit_a;
    logic               sbit_b;
    logic [DIV_W:0]     rsh_a;
    logic [DIV_W:0]     rsh_b;
    logic               ge_a;
    logic               ge_b;
    logic [DIV_W:0]     diff_a;
    logic [DIV_W:0]     diff_b;

    // window bounds and divisor from the frequency code
    assign start_tick = {5'b0, pwm_freq_reg, 1'b0};
    assign end_tick   = {1'b0, pwm_freq_reg, 5'b0} + {3'b0, pwm_freq_reg, 3'b0};
    assign divisor    = {1'b0, pwm_freq_reg, 5'b0} + {4'b0, pwm_freq_reg, 2'b0}
                      + {5'b0, pwm_freq_reg, 1'b0};

    // dc bus window
    assign bus_scaled  = {1'b0, sample.dc_bus_volts, 8'b0};
    assign bus_lo      = BUS_W'(supply_reg) * BUS_LO_MUL;
    assign bus_hi      = BUS_W'(supply_reg) * BUS_HI_MUL;
    assign bus_outside = (bus_scaled < bus_lo) || (bus_scaled > bus_hi);

    always_comb
    begin
        if (bus_outside)
        begin
            timer_upd = (timer_reg != TIMER_MAX) ? timer_reg + 8'd1 : timer_reg;
        end
        else
        begin
            timer_upd = (timer_reg != '0) ? timer_reg - 8'd1 : timer_reg;
        end
    end

    // serial adder bits
    assign bit_a  = a_sh_reg[0];
    assign bit_b  = b_sh_reg[0];
    assign sbit_a = sum_a_reg[0] ^ bit_a ^ carry_a_reg;
    assign sbit_b = sum_b_reg[0] ^ bit_b ^ carry_b_reg;

    // restoring divider step
    assign rsh_a  = {rem_a_reg, sum_a_reg[SUM_W-1]};
    assign rsh_b  = {rem_b_reg, sum_b_reg[SUM_W-1]};
    assign diff_a = rsh_a - {1'b0, divisor};
    assign diff_b = rsh_b - {1'b0, divisor};
    assign ge_a   = rsh_a >= {1'b0, divisor};
    assign ge_b   = rsh_b >= {1'b0, divisor};

    always_comb
    begin
        state_next        = state_reg;
        tick_next         = tick_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        timer_next        = timer_reg;
        fault_next        = fault_reg;
        class_next        = class_reg;
        done_next         = done_reg;
        ofs_a_next        = ofs_a_reg;
        ofs_b_next        = ofs_b_reg;
        cnt_next          = cnt_reg;
        carry_a_next      = carry_a_reg;
        carry_b_next      = carry_b_reg;
        a_sh_next         = a_sh_reg;
        b_sh_next         = b_sh_reg;
        rem_a_next        = rem_a_reg;
        rem_b_next        = rem_b_reg;
        q_a_next          = q_a_reg;
        q_b_next          = q_b_reg;
        neg_a_next        = neg_a_reg;
        neg_b_next        = neg_b_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        sample_ready      = (state_reg == ST_IDLE);

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    priority if (done_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (tick_reg <= start_tick)
                    begin
                        tick_next  = tick_reg + 14'd1;
                        sum_a_next = '0;
                        sum_b_next = '0;
                        timer_next = '0;
                        state_next = ST_OUT;
                    end
                    else if (tick_reg <= end_tick)
                    begin
                        class_next   = (sample.vclass_adc >= VCLASS_THRESHOLD);
                        timer_next   = timer_upd;
                        fault_next   = fault_reg | (timer_upd > TIMER_LIMIT);
                        tick_next    = tick_reg + 14'd1;
                        a_sh_next    = sample.phase_a_current;
                        b_sh_next    = sample.phase_b_current;
                        carry_a_next = 1'b0;
                        carry_b_next = 1'b0;
                        cnt_next     = '0;
                        state_next   = ST_SUM;
                    end
                    else if (divisor == '0)
                    begin
                        ofs_a_next = '0;
                        ofs_b_next = '0;
                        done_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // sums are dead after this, so they carry the dividend magnitudes
                        neg_a_next = sum_a_reg[SUM_W-1];
                        neg_b_next = sum_b_reg[SUM_W-1];
                        sum_a_next = sum_a_reg[SUM_W-1] ? (-sum_a_reg) : sum_a_reg;
                        sum_b_next = sum_b_reg[SUM_W-1] ? (-sum_b_reg) : sum_b_reg;
                        rem_a_next = '0;
                        rem_b_next = '0;
                        q_a_next   = '0;
                        q_b_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_SUM:
            begin
                sum_a_next   = {sbit_a, sum_a_reg[SUM_W-1:1]};
                sum_b_next   = {sbit_b, sum_b_reg[SUM_W-1:1]};
                carry_a_next = (sum_a_reg[0] & bit_a) | (sum_a_reg[0] & carry_a_reg)
                             | (bit_a & carry_a_reg);
                carry_b_next = (sum_b_reg[0] & bit_b) | (sum_b_reg[0] & carry_b_reg)
                             | (bit_b & carry_b_reg);
                // sign extension of the sample
                a_sh_next    = {a_sh_reg[OFS_W-1], a_sh_reg[OFS_W-1:1]};
                b_sh_next    = {b_sh_reg[OFS_W-1], b_sh_reg[OFS_W-1:1]};
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = ST_OUT;
                end
            end

            ST_DIV:
            begin
                rem_a_next = ge_a ? diff_a[DIV_W-1:0] : rsh_a[DIV_W-1:0];
                rem_b_next = ge_b ? diff_b[DIV_W-1:0] : rsh_b[DIV_W-1:0];
                q_a_next   = {q_a_reg[OFS_W-2:0], ge_a};
                q_b_next   = {q_b_reg[OFS_W-2:0], ge_b};
                sum_a_next = {sum_a_reg[SUM_W-2:0], 1'b0};
                sum_b_next = {sum_b_reg[SUM_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == LAST_BIT)
                begin
                    ofs_a_next = neg_a_reg ? (-q_a_next) : q_a_next;
                    ofs_b_next = neg_b_reg ? (-q_b_next) : q_b_next;
                    done_next  = 1'b1;
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.offset_a     = done_reg ? ofs_a_reg : '0;
                    result_next.offset_b     = done_reg ? ofs_b_reg : '0;
                    result_next.cal_done     = done_reg;
                    result_next.class_high   = class_reg;
                    result_next.charge_fault = fault_reg;
                    result_valid_next        = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_freq_reg <= PWM_FREQ_RESET;
            supply_reg   <= SUPPLY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PWM_FREQ: pwm_freq_reg <= cfg_data[7:0];
                CFG_SUPPLY:   supply_reg   <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tick_reg         <= '0;
            sum_a_reg        <= '0;
            sum_b_reg        <= '0;
            timer_reg        <= '0;
            fault_reg        <= 1'b0;
            class_reg        <= 1'b0;
            done_reg         <= 1'b0;
            ofs_a_reg        <= '0;
            ofs_b_reg        <= '0;
            cnt_reg          <= '0;
            carry_a_reg      <= 1'b0;
            carry_b_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tick_reg         <= tick_next;
            sum_a_reg        <= sum_a_next;
            sum_b_reg        <= sum_b_next;
            timer_reg        <= timer_next;
            fault_reg        <= fault_next;
            class_reg        <= class_next;
            done_reg         <= done_next;
            ofs_a_reg        <= ofs_a_next;
            ofs_b_reg        <= ofs_b_next;
            cnt_reg          <= cnt_next;
            carry_a_reg      <= carry_a_next;
            carry_b_reg      <= carry_b_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_sh_reg   <= a_sh_next;
        b_sh_reg   <= b_sh_next;
        rem_a_reg  <= rem_a_next;
        rem_b_reg  <= rem_b_next;
        q_a_reg    <= q_a_next;
        q_b_reg    <= q_b_next;
        neg_a_reg  <= neg_a_next;
        neg_b_reg  <= neg_b_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
